FILE: hw/rtl/sorted_timer_queue_defines.svh
// Assertion helpers for the RTL.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

`define STQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/stq_pkg.sv
package stq_pkg;

  localparam int unsigned StqDepth = 16;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_CANCEL  = 2'd1,
    FUNC_FINDDEL = 2'd2,
    FUNC_POP     = 2'd3
  } stq_func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_NOTYET   = 2'd2,
    ST_FULL     = 2'd3
  } stq_status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic [15:0] pkt_id;
    logic [15:0] seq;
    logic [19:0] delay;
  } stq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pkt_out;
    logic [32:0] value;
  } stq_out_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] seq;
    logic [32:0] deadline;
  } stq_entry_t;

endpackage

FILE: hw/rtl/sorted_timer_queue.sv
// Channel  | Ports                 | Handshake
// ---------+-----------------------+-----------------------------------------
// input    | start, busy, in_item  | taken at an edge with start && !busy
// result   | out_valid, out_item   | one-cycle strobe, receiver cannot stall
//
// Entries sit packed in deadline order in one memory (one read, one write
// port, registered read). An item walks the n live entries one per cycle:
// a scan over the table, then on a hit a removal that shifts the entries
// above it down, then for a request with room an insert that shifts the
// entries up and writes the new one; the strobe follows the DONE state.
// Busy holds from the accepting edge and drops with the strobe. Reset
// empties the table through the count register alone.
`include "sorted_timer_queue_defines.svh"
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = StqDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  stq_in_t  in_item,
  output logic     out_valid,
  output stq_out_t out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_REM, S_INS, S_DONE
  } state_t;

  stq_entry_t mem [DEPTH];
  stq_entry_t rd_q;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;    // next entry to read (INS: one above it)
  logic [CW-1:0] ridx_r;   // entry held in rd_q
  logic          rdv_r;    // rd_q is valid
  logic [CW-1:0] hit_r;
  logic          found_r;
  logic [CW-1:0] pos_r;
  stq_in_t       req_r;
  stq_out_t      res_r;
  logic          ov_r;
  logic          busy_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  stq_entry_t    wd;
  logic [32:0]   dl;
  logic [32:0]   now_x;
  logic          rd_go;
  logic          walk_end;
  stq_func_t     func;

  assign dl       = {1'b0, req_r.now} + {13'd0, req_r.delay};
  assign now_x    = {1'b0, req_r.now};
  assign func     = stq_func_t'(req_r.func);
  assign walk_end = !rd_go && !rdv_r;

  // Reads run ahead of the shifted writes in both directions, so a read
  // never meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_comb begin
    we    = 1'b0;
    wa    = '0;
    wd    = rd_q;
    ra    = '0;
    rd_go = 1'b0;
    unique case (state_r)
      S_SCAN, S_REM: begin
        rd_go = idx_r < cnt_r;
        ra    = AW'(idx_r);
        if (state_r == S_REM && rdv_r) begin
          // shift entry down over the removed one
          we = 1'b1;
          wa = AW'(ridx_r - CW'(1));
        end
      end
      S_INS: begin
        rd_go = idx_r > pos_r;
        ra    = AW'(idx_r - CW'(1));
        if (rdv_r) begin
          we = 1'b1;
          wa = AW'(ridx_r + CW'(1));
        end else if (!rd_go) begin
          we = 1'b1;
          wa = AW'(pos_r);
          wd = '{handle: req_r.pkt_id, seq: req_r.seq, deadline: dl};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      ridx_r  <= '0;
      rdv_r   <= 1'b0;
      hit_r   <= '0;
      found_r <= 1'b0;
      pos_r   <= '0;
      req_r   <= '0;
      res_r   <= '0;
      ov_r    <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      ov_r  <= (state_r == S_DONE);
      rdv_r <= rd_go;
      if (rd_go) ridx_r <= (state_r == S_INS) ? idx_r - CW'(1) : idx_r;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= in_item;
            busy_r  <= 1'b1;
            idx_r   <= '0;
            found_r <= 1'b0;
            pos_r   <= '0;
            res_r   <= '{status: ST_NOTFOUND, pkt_out: '0, value: '0};
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_go) idx_r <= idx_r + CW'(1);
          if (rdv_r) begin
            unique case (func)
              FUNC_REQUEST: begin
                // count entries that stay ahead of the new deadline
                if (!found_r && rd_q.handle == req_r.pkt_id) begin
                  found_r <= 1'b1;
                  hit_r   <= ridx_r;
                end else if (rd_q.deadline <= dl) begin
                  pos_r <= pos_r + CW'(1);
                end
              end
              FUNC_CANCEL: begin
                if (!found_r && rd_q.handle == req_r.pkt_id) begin
                  found_r      <= 1'b1;
                  hit_r        <= ridx_r;
                  res_r.status <= ST_OK;
                  res_r.value  <= (rd_q.deadline > now_x) ? rd_q.deadline - now_x : '0;
                end
              end
              FUNC_FINDDEL: begin
                if (!found_r && rd_q.seq == req_r.seq) begin
                  found_r       <= 1'b1;
                  hit_r         <= ridx_r;
                  res_r.status  <= ST_OK;
                  res_r.pkt_out <= rd_q.handle;
                end
              end
              FUNC_POP: begin
                if (ridx_r == '0) begin
                  if (rd_q.deadline > now_x) begin
                    res_r.status <= ST_NOTYET;
                  end else begin
                    found_r       <= 1'b1;
                    hit_r         <= '0;
                    res_r.status  <= ST_OK;
                    res_r.pkt_out <= rd_q.handle;
                  end
                end
              end
            endcase
          end
          if (walk_end) begin
            if (found_r) begin
              idx_r   <= hit_r + CW'(1);
              state_r <= S_REM;
            end else if (func == FUNC_REQUEST && cnt_r != CW'(DEPTH)) begin
              idx_r   <= cnt_r;
              state_r <= S_INS;
            end else begin
              if (func == FUNC_REQUEST) res_r.status <= ST_FULL;
              state_r <= S_DONE;
            end
          end
        end
        S_REM: begin
          if (rd_go) idx_r <= idx_r + CW'(1);
          if (walk_end) begin
            cnt_r <= cnt_r - CW'(1);
            if (func == FUNC_REQUEST) begin
              idx_r   <= cnt_r - CW'(1);
              state_r <= S_INS;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_INS: begin
          if (rd_go) idx_r <= idx_r - CW'(1);
          if (walk_end) begin
            cnt_r        <= cnt_r + CW'(1);
            res_r.status <= ST_OK;
            res_r.value  <= dl;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          busy_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = ov_r;
  assign out_item  = res_r;

  `STQ_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH), "count beyond depth")
  `STQ_ASSERT_NEXT(a_done_out, clk, rst_n, state_r == S_DONE, ov_r && !busy_r, "no result")
  `STQ_ASSERT_IMPL(a_idle_free, clk, rst_n, state_r == S_IDLE, !busy_r, "busy while idle")
  `STQ_ASSERT_IMPL(a_out_idle, clk, rst_n, ov_r, state_r == S_IDLE, "result outside idle")
  `STQ_ASSERT_IMPL(a_walk_busy, clk, rst_n, state_r != S_IDLE, busy_r, "idle during walk")

endmodule
